// ===== src/mmc_pkg.sv =====
`default_nettype none
package mmc_pkg;

  localparam logic [7:0] UNSET_DATA      = 8'hFF;
  localparam logic [7:0] READING_DATA    = 8'hFE;
  localparam logic [4:0] INHERIT_CHANNEL = 5'd16;
  localparam logic [7:0] DATA_MASK       = 8'h7F;
  localparam logic [7:0] STATUS_MASK     = 8'hF0;
  localparam logic [7:0] CHANNEL_MASK    = 8'h0F;

  localparam logic [3:0] KIND_NOTE_OFF   = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON    = 4'h9;
  localparam logic [3:0] KIND_POLY_AT    = 4'hA;
  localparam logic [3:0] KIND_CTRL       = 4'hB;
  localparam logic [3:0] KIND_PROGRAM    = 4'hC;
  localparam logic [3:0] KIND_CHAN_AT    = 4'hD;
  localparam logic [3:0] KIND_PITCH_BEND = 4'hE;
  localparam logic [3:0] KIND_SYSTEM     = 4'hF;

  localparam logic [7:0] SYS_QUARTER_FRAME = 8'hF1;
  localparam logic [7:0] SYS_SONG_POSITION = 8'hF2;
  localparam logic [7:0] SYS_SONG_SELECT   = 8'hF3;
  localparam logic [7:0] SYS_TUNE_REQUEST  = 8'hF6;
  localparam logic [7:0] SYS_CLOCK         = 8'hF8;
  localparam logic [7:0] SYS_START         = 8'hFA;
  localparam logic [7:0] SYS_CONTINUE      = 8'hFB;
  localparam logic [7:0] SYS_STOP          = 8'hFC;
  localparam logic [7:0] SYS_ACTIVE_SENSE  = 8'hFE;
  localparam logic [7:0] SYS_RESET         = 8'hFF;

  typedef struct packed {
    logic       changing;
    logic [8:0] status_on_change;
    logic [8:0] status_on_stop;
    logic [7:0] manual_change_first;
    logic [7:0] manual_change_second;
    logic [7:0] manual_stop_first;
    logic [7:0] manual_stop_second;
    logic [4:0] device_channel;
    logic [3:0] module_channel;
    logic [7:0] device_data;
    logic [6:0] press_velocity;
    logic [6:0] reading;
  } in_t;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       last_byte;
  } out_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      last_idx;
  } msg_t;

endpackage
`default_nettype wire

// ===== src/mmc_front.sv =====
`default_nettype none
module mmc_front
  import mmc_pkg::*;
(
  input  in_t  item,
  output logic valid,
  output msg_t msg
);

  logic [8:0] st;
  logic [7:0] m0;
  logic [7:0] m1;
  logic [7:0] num;
  logic [7:0] vel;
  logic [7:0] rd;
  logic [3:0] ch;
  logic [3:0] kind;
  logic       sys_ok;
  logic [7:0] def0;
  logic [7:0] def1;

  function automatic logic [7:0] pick(input logic [7:0] manual, input logic [7:0] fallback,
                                      input logic [7:0] rdv);
    logic [7:0] r;
    if (manual == UNSET_DATA) begin
      r = fallback & DATA_MASK;
    end else if (manual == READING_DATA) begin
      r = rdv & DATA_MASK;
    end else begin
      r = manual & DATA_MASK;
    end
    return r;
  endfunction

  always_comb begin
    st   = item.changing ? item.status_on_change : item.status_on_stop;
    m0   = item.changing ? item.manual_change_first : item.manual_stop_first;
    m1   = item.changing ? item.manual_change_second : item.manual_stop_second;
    num  = (item.device_data == UNSET_DATA) ? 8'd0 : item.device_data;
    vel  = {1'b0, item.press_velocity};
    rd   = {1'b0, item.reading};
    ch   = (item.device_channel == INHERIT_CHANNEL) ? item.module_channel
                                                   : item.device_channel[3:0];
    kind = st[7:4];

    sys_ok = (st[7:0] == SYS_QUARTER_FRAME) || (st[7:0] == SYS_SONG_POSITION) ||
             (st[7:0] == SYS_SONG_SELECT) || (st[7:0] == SYS_TUNE_REQUEST) ||
             (st[7:0] == SYS_CLOCK) || (st[7:0] == SYS_START) ||
             (st[7:0] == SYS_CONTINUE) || (st[7:0] == SYS_STOP) ||
             (st[7:0] == SYS_ACTIVE_SENSE) || (st[7:0] == SYS_RESET);
    valid = !st[8] && st[7] && ((kind != KIND_SYSTEM) || sys_ok);

    def0 = num;
    def1 = num;
    msg.last_idx = 2'd2;
    msg.bytes[0] = (st[7:0] & STATUS_MASK) | {4'h0, ch & CHANNEL_MASK[3:0]};
    case (kind)
      KIND_NOTE_OFF, KIND_NOTE_ON: begin
        def1 = vel;
      end
      KIND_POLY_AT, KIND_CTRL: begin
        def1 = rd;
      end
      KIND_PROGRAM: begin
        msg.last_idx = 2'd1;
      end
      KIND_CHAN_AT: begin
        def0 = rd;
        msg.last_idx = 2'd1;
      end
      KIND_PITCH_BEND: begin
        def0 = rd;
        def1 = rd;
      end
      KIND_SYSTEM: begin
        msg.bytes[0] = st[7:0];
        if (st[7:0] == SYS_SONG_POSITION) begin
          def0 = rd;
          def1 = rd;
          msg.last_idx = 2'd2;
        end else if ((st[7:0] == SYS_QUARTER_FRAME) || (st[7:0] == SYS_SONG_SELECT)) begin
          msg.last_idx = 2'd1;
        end else begin
          msg.last_idx = 2'd0;
        end
      end
      default: begin
        def0 = num;
      end
    endcase
    msg.bytes[1] = pick(m0, def0, rd);
    msg.bytes[2] = pick(m1, def1, rd);
  end

endmodule
`default_nettype wire

// ===== src/mmc_queue.sv =====
`default_nettype none
module mmc_queue
  import mmc_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   push,
  input  msg_t  push_msg,
  input  wire   pop,
  output msg_t  head_msg,
  output logic  empty,
  output logic  full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  msg_t            mem [DEPTH];
  msg_t            head_r;
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == FULL_CNT);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_msg = head_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  // head register tracks the entry at the next read pointer, bypassing a same-cycle write
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_msg;
    end
    if (do_push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= push_msg;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/mmc_back.sv =====
`default_nettype none
module mmc_back
  import mmc_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  wire   q_empty,
  input  msg_t  q_head,
  output logic  q_pop,
  output logic  out_valid,
  output out_t  out_data
);

  logic       cur_valid_r, cur_valid_nxt;
  msg_t       cur_r, cur_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       at_last;

  assign at_last            = (idx_r == cur_r.last_idx);
  assign q_pop              = (!cur_valid_r || at_last) && !q_empty;
  assign out_valid          = cur_valid_r;
  assign out_data.msg_byte  = cur_r.bytes[idx_r];
  assign out_data.last_byte = at_last;

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      cur_nxt       = q_head;
      idx_nxt       = 2'd0;
    end else if (cur_valid_r) begin
      if (at_last) begin
        cur_valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/midi_message_composer_top.sv =====
// Takes one control event per start/!busy transaction and sends the resulting
// MIDI message as 1 to 3 bytes, one byte per cycle on out_valid, status byte
// first, last_byte on the final byte. The receiver cannot stall: every byte
// stands on the outputs for exactly one cycle. Events are classified as they
// are accepted and queued (QUEUE_DEPTH messages); busy is high only while the
// queue is full. The byte serializer sets the sustained event rate by the
// byte count of each message. An event with an unset or unsupported status
// is accepted and produces no bytes. When idle, an accepted event is first
// registered at the queue head, then loaded into the serializer for output.
`default_nettype none
module midi_message_composer_top
  import mmc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   start,
  output logic  busy,
  input  in_t   in_data,
  output logic  out_valid,
  output out_t  out_data
);

  logic q_full;
  logic q_empty;
  logic q_pop;
  logic msg_ok;
  msg_t front_msg;
  msg_t head_msg;

  assign busy = q_full;

  mmc_front u_front (
    .item  (in_data),
    .valid (msg_ok),
    .msg   (front_msg)
  );

  mmc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (start && msg_ok),
    .push_msg (front_msg),
    .pop      (q_pop),
    .head_msg (head_msg),
    .empty    (q_empty),
    .full     (q_full)
  );

  mmc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (head_msg),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
